// File: rtl/tpw_pkg.sv
// Shared constants and types for the trapezoid pulse waveform block.
package tpw_pkg;

    // Default field widths.
    localparam int DEF_TIME_BITS  = 40;
    localparam int DEF_LEVEL_BITS = 24;

    // Configuration port geometry: 64-bit data, registers on 8-byte boundaries.
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_BASE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PULSE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RISE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FALL   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd6;

    // Waveform segment codes.
    localparam int SEG_W = 3;

    typedef enum logic [SEG_W-1:0] {
        SEG_DELAY = 3'd0,
        SEG_RISE  = 3'd1,
        SEG_HIGH  = 3'd2,
        SEG_FALL  = 3'd3,
        SEG_REST  = 3'd4
    } seg_t;

endpackage

// File: rtl/tpw_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tpw_div_pipe #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 40,
    parameter int Q_W    = 24,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [DEN_W-1:0]  rem,
    output logic [SIDE_W-1:0] side_out
);

    // Stage registers; the upper bits of num must already be below den.
    logic              valid_reg [Q_W];
    logic [DEN_W-1:0]  rem_reg   [Q_W];
    logic [Q_W-1:0]    low_reg   [Q_W];
    logic [Q_W-1:0]    quo_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic              valid_src;
        logic [DEN_W-1:0]  rem_src;
        logic [Q_W-1:0]    low_src;
        logic [Q_W-1:0]    quo_src;
        logic [DEN_W-1:0]  den_src;
        logic [SIDE_W-1:0] side_src;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign valid_src = in_valid;
            assign rem_src   = DEN_W'(num[NUM_W-1:Q_W]);
            assign low_src   = num[Q_W-1:0];
            assign quo_src   = '0;
            assign den_src   = den;
            assign side_src  = side;
        end else begin : g_next
            assign valid_src = valid_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign low_src   = low_reg[k-1];
            assign quo_src   = quo_reg[k-1];
            assign den_src   = den_reg[k-1];
            assign side_src  = side_reg[k-1];
        end

        // Shift in the next dividend bit and try one subtraction.
        assign trial = {rem_src, low_src[Q_W-1]};
        assign diff  = trial - {1'b0, den_src};
        assign ge    = ~diff[DEN_W];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                low_reg[k]  <= low_src << 1;
                quo_reg[k]  <= {quo_src[Q_W-2:0], ge};
                den_reg[k]  <= den_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign rem       = rem_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

// File: rtl/trapezoid_pulse_waveform.sv
// Periodic trapezoid pulse waveform: time stamp in, level and segment out.
// Throughput: one item per cycle while the skid stage is empty; the period fold and
// the ramp division are restoring dividers pipelined one bit per stage, and the output
// register plus a skid stage absorb stalls.
// Reset: rst_n clears all valid bits and every configuration register to zero.
module trapezoid_pulse_waveform #(
    parameter int TIME_BITS  = tpw_pkg::DEF_TIME_BITS,
    parameter int LEVEL_BITS = tpw_pkg::DEF_LEVEL_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tpw_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [tpw_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [tpw_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0]         s_tdata,  // time_ps
    // Output stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((LEVEL_BITS+7)/8)*8-1:0]        m_tdata,  // level
    output logic [tpw_pkg::SEG_W-1:0]              m_tuser   // segment
);

    import tpw_pkg::*;

    localparam int TW       = TIME_BITS;
    localparam int LW       = LEVEL_BITS;
    localparam int M_DATA_W = ((LEVEL_BITS + 7) / 8) * 8;
    localparam int NUM_W    = TW + LW;
    localparam int HALF     = TW / 2;
    localparam int MOD_SIDE = TW + 2;
    localparam int DIV_SIDE = SEG_W + 1 + LW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LW-1:0]        base_reg;
    logic [LW-1:0]        pulse_reg;
    logic [TW-1:0]        delay_reg;
    logic [TW-1:0]        rise_reg;
    logic [TW-1:0]        fall_reg;
    logic [TW-1:0]        width_reg;
    logic [TW-1:0]        period_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Register write on the access cycle of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            pulse_reg  <= '0;
            delay_reg  <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            width_reg  <= '0;
            period_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_BASE:   base_reg   <= pwdata[LW-1:0];
                REG_PULSE:  pulse_reg  <= pwdata[LW-1:0];
                REG_DELAY:  delay_reg  <= pwdata[TW-1:0];
                REG_RISE:   rise_reg   <= pwdata[TW-1:0];
                REG_FALL:   fall_reg   <= pwdata[TW-1:0];
                REG_WIDTH:  width_reg  <= pwdata[TW-1:0];
                REG_PERIOD: period_reg <= pwdata[TW-1:0];
                default:    ;
            endcase
        end
    end

    // Register read.
    always_comb
    begin
        case (reg_idx)
            REG_BASE:   prdata = APB_DATA_W'(base_reg);
            REG_PULSE:  prdata = APB_DATA_W'(pulse_reg);
            REG_DELAY:  prdata = APB_DATA_W'(delay_reg);
            REG_RISE:   prdata = APB_DATA_W'(rise_reg);
            REG_FALL:   prdata = APB_DATA_W'(fall_reg);
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_PERIOD: prdata = APB_DATA_W'(period_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves while the skid stage is empty.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic pipe_en;

    assign pipe_en  = ~skid_valid_reg;
    assign s_tready = pipe_en;

    // Stage A: delay compare and elapsed time.
    logic          a_valid_reg;
    logic          a_pre_reg;
    logic [TW-1:0] a_e_reg;
    logic [TW-1:0] time_in;

    assign time_in = s_tdata[TW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_pre_reg <= (time_in <= delay_reg);
            a_e_reg   <= time_in - delay_reg;
        end
    end

    // Stage B: decide whether the elapsed time is folded into the period.
    logic          b_valid_reg;
    logic          b_pre_reg;
    logic          b_fold_reg;
    logic [TW-1:0] b_e_reg;
    logic [TW-1:0] b_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            b_pre_reg  <= a_pre_reg;
            b_fold_reg <= (period_reg != '0) && (a_e_reg > period_reg);
            b_e_reg    <= a_e_reg;
            b_x_reg    <= a_e_reg - TW'(1);
        end
    end

    // Period fold: remainder of (elapsed - 1) by the period.
    logic                mod_valid;
    logic [TW-1:0]       mod_rem;
    logic [MOD_SIDE-1:0] mod_side;

    tpw_div_pipe #(
        .NUM_W  (TW + 1),
        .DEN_W  (TW),
        .Q_W    (TW),
        .SIDE_W (MOD_SIDE)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (b_valid_reg),
        .num       ({1'b0, b_x_reg}),
        .den       (period_reg),
        .side      ({b_pre_reg, b_fold_reg, b_e_reg}),
        .out_valid (mod_valid),
        .quo       (),
        .rem       (mod_rem),
        .side_out  (mod_side)
    );

    // Stage C1: time within the period.
    logic          c1_valid_reg;
    logic          c1_pre_reg;
    logic [TW-1:0] c1_tf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            c1_valid_reg <= mod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c1_pre_reg <= mod_side[TW+1];
            c1_tf_reg  <= mod_side[TW] ? (mod_rem + TW'(1)) : mod_side[TW-1:0];
        end
    end

    // Stage C2: rise boundary.
    logic          c2_valid_reg;
    logic          c2_pre_reg;
    logic          c2_le_rise_reg;
    logic [TW-1:0] c2_tf_reg;
    logic [TW-1:0] c2_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c2_pre_reg     <= c1_pre_reg;
            c2_le_rise_reg <= (c1_tf_reg <= rise_reg);
            c2_tf_reg      <= c1_tf_reg;
            c2_t2_reg      <= c1_tf_reg - rise_reg;
        end
    end

    // Stage C3: plateau boundary.
    logic          c3_valid_reg;
    logic          c3_pre_reg;
    logic          c3_le_rise_reg;
    logic          c3_le_w_reg;
    logic [TW-1:0] c3_tf_reg;
    logic [TW-1:0] c3_t3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            c3_valid_reg <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c3_pre_reg     <= c2_pre_reg;
            c3_le_rise_reg <= c2_le_rise_reg;
            c3_le_w_reg    <= (c2_t2_reg <= width_reg);
            c3_tf_reg      <= c2_tf_reg;
            c3_t3_reg      <= c2_t2_reg - width_reg;
        end
    end

    // Stage C4: pick the segment and the ramp operands. Flat segments use a
    // zero ramp over a unit duration so the level falls out of the same path.
    seg_t          c4_seg;
    logic [TW-1:0] c4_t;
    logic [TW-1:0] c4_dur;
    logic [LW-1:0] c4_from;
    logic [LW-1:0] c4_to;

    always_comb
    begin
        c4_seg  = SEG_REST;
        c4_t    = '0;
        c4_dur  = TW'(1);
        c4_from = base_reg;
        c4_to   = base_reg;
        if (c3_pre_reg)
        begin
            c4_seg = SEG_DELAY;
        end
        else if (c3_le_rise_reg)
        begin
            c4_seg = SEG_RISE;
            c4_t   = c3_tf_reg;
            c4_dur = rise_reg;
            c4_to  = pulse_reg;
        end
        else if (c3_le_w_reg)
        begin
            c4_seg  = SEG_HIGH;
            c4_from = pulse_reg;
            c4_to   = pulse_reg;
        end
        else if (c3_t3_reg < fall_reg)
        begin
            c4_seg  = SEG_FALL;
            c4_t    = c3_t3_reg;
            c4_dur  = fall_reg;
            c4_from = pulse_reg;
        end
    end

    logic          s4_valid_reg;
    seg_t          s4_seg_reg;
    logic [TW-1:0] s4_t_reg;
    logic [TW-1:0] s4_dur_reg;
    logic [LW-1:0] s4_from_reg;
    logic [LW-1:0] s4_to_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s4_valid_reg <= c3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s4_seg_reg  <= c4_seg;
            s4_t_reg    <= c4_t;
            s4_dur_reg  <= c4_dur;
            s4_from_reg <= c4_from;
            s4_to_reg   <= c4_to;
        end
    end

    // Stage C5: level difference as sign and magnitude.
    logic [LW:0]   c5_diff;
    logic [LW:0]   c5_neg_diff;
    logic          s5_valid_reg;
    seg_t          s5_seg_reg;
    logic [TW-1:0] s5_t_reg;
    logic [TW-1:0] s5_dur_reg;
    logic [LW-1:0] s5_from_reg;
    logic          s5_neg_reg;
    logic [LW-1:0] s5_mag_reg;

    assign c5_diff     = {s4_to_reg[LW-1], s4_to_reg} - {s4_from_reg[LW-1], s4_from_reg};
    assign c5_neg_diff = -c5_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s5_seg_reg  <= s4_seg_reg;
            s5_t_reg    <= s4_t_reg;
            s5_dur_reg  <= s4_dur_reg;
            s5_from_reg <= s4_from_reg;
            s5_neg_reg  <= c5_diff[LW];
            s5_mag_reg  <= c5_diff[LW] ? c5_neg_diff[LW-1:0] : c5_diff[LW-1:0];
        end
    end

    // Stage C6: two partial products of time by magnitude.
    logic                 s6_valid_reg;
    seg_t                 s6_seg_reg;
    logic [TW-1:0]        s6_dur_reg;
    logic [LW-1:0]        s6_from_reg;
    logic                 s6_neg_reg;
    logic [HALF+LW-1:0]   s6_plo_reg;
    logic [TW-HALF+LW-1:0] s6_phi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s6_seg_reg  <= s5_seg_reg;
            s6_dur_reg  <= s5_dur_reg;
            s6_from_reg <= s5_from_reg;
            s6_neg_reg  <= s5_neg_reg;
            s6_plo_reg  <= s5_t_reg[HALF-1:0] * s5_mag_reg;
            s6_phi_reg  <= s5_t_reg[TW-1:HALF] * s5_mag_reg;
        end
    end

    // Stage C7: combine the partial products into the dividend.
    logic             s7_valid_reg;
    seg_t             s7_seg_reg;
    logic [TW-1:0]    s7_dur_reg;
    logic [LW-1:0]    s7_from_reg;
    logic             s7_neg_reg;
    logic [NUM_W-1:0] s7_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s7_seg_reg  <= s6_seg_reg;
            s7_dur_reg  <= s6_dur_reg;
            s7_from_reg <= s6_from_reg;
            s7_neg_reg  <= s6_neg_reg;
            s7_num_reg  <= NUM_W'(s6_plo_reg) + (NUM_W'(s6_phi_reg) << HALF);
        end
    end

    // Ramp division: quotient never exceeds the magnitude, so LW bits suffice.
    logic                div_valid;
    logic [LW-1:0]       div_quo;
    logic [DIV_SIDE-1:0] div_side;
    seg_t                div_seg;
    logic                div_neg;
    logic [LW-1:0]       div_from;

    tpw_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (TW),
        .Q_W    (LW),
        .SIDE_W (DIV_SIDE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s7_valid_reg),
        .num       (s7_num_reg),
        .den       (s7_dur_reg),
        .side      ({s7_seg_reg, s7_neg_reg, s7_from_reg}),
        .out_valid (div_valid),
        .quo       (div_quo),
        .rem       (),
        .side_out  (div_side)
    );

    assign div_seg  = seg_t'(div_side[DIV_SIDE-1:LW+1]);
    assign div_neg  = div_side[LW];
    assign div_from = div_side[LW-1:0];

    // Stage F: apply the ramp step to the starting level.
    logic          f_valid_reg;
    seg_t          f_seg_reg;
    logic [LW-1:0] f_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            f_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            f_seg_reg   <= div_seg;
            f_level_reg <= div_neg ? (div_from - div_quo) : (div_from + div_quo);
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    logic          out_valid_reg;
    logic          out_valid_next;
    seg_t          out_seg_reg;
    logic [LW-1:0] out_level_reg;
    logic          skid_valid_next;
    seg_t          skid_seg_reg;
    logic [LW-1:0] skid_level_reg;
    logic          load_f;
    logic          take;
    logic          out_from_skid;
    logic          out_from_f;
    logic          skid_load;

    assign load_f        = pipe_en & f_valid_reg;
    assign take          = out_valid_reg & m_tready;
    assign out_from_skid = take & skid_valid_reg;
    assign out_from_f    = load_f & (~out_valid_reg | take);
    assign skid_load     = load_f & out_valid_reg & ~m_tready;

    assign out_valid_next  = out_from_skid | out_from_f | (out_valid_reg & ~take);
    assign skid_valid_next = skid_load | (skid_valid_reg & ~take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            out_seg_reg   <= skid_seg_reg;
            out_level_reg <= skid_level_reg;
        end
        else if (out_from_f)
        begin
            out_seg_reg   <= f_seg_reg;
            out_level_reg <= f_level_reg;
        end
        if (skid_load)
        begin
            skid_seg_reg   <= f_seg_reg;
            skid_level_reg <= f_level_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_level_reg);
    assign m_tuser  = out_seg_reg;

endmodule
